>>> src/rgbhsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to HSI shared definitions
// CORDIC arctangent table, widths and helper constants for the converter.
// -----------------------------------------------------------------------------
package rgbhsi_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 12;
  localparam int unsigned ROT_STEPS      = 28;
  localparam int unsigned CW             = 34;   // CORDIC x/y width
  localparam int unsigned ZW             = 34;   // angle accumulator width
  localparam int unsigned SQRT3_Q16      = 113512;
  localparam int unsigned FRAC_BITS      = 12;
  // Dividend/divisor widths for the saturation divider.
  localparam int unsigned SAT_NW         = 24;
  localparam int unsigned SAT_DW         = 11;
  localparam int unsigned SAT_QW         = 13;

  // Per-pixel control that travels beside the CORDIC datapath.
  typedef struct packed {
    logic       gray_gb;   // green equals blue
    logic       xneg;      // 2r-g-b is negative
    logic       dneg;      // green below blue
  } hue_ctl_t;

  function automatic logic [ZW-1:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000; 1:  t = 32'h12E4051E; 2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4; 4:  t = 32'h028B0D43; 5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E; 7:  t = 32'h00517C55; 8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005;
      default: t = 32'h0;
    endcase
    return {{(ZW-32){1'b0}}, t};
  endfunction

endpackage
`default_nettype wire

>>> src/rgb_to_hsi_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to HSI converter core
// Pipelined conversion of 8-bit RGB pixels into 12-bit hue, Q1.12 S and I.
// -----------------------------------------------------------------------------
// The core accepts one pixel transaction every clock while the result side does
// not stall and returns one result transaction per pixel, in order, through one
// input stage, 28 CORDIC rotation stages, one hue rounding stage and one output
// register. Hue is atan2(sqrt(3)*(g-b), 2r-g-b) as a fraction of a full turn;
// saturation uses a pipelined restoring divider whose stages run beside the
// CORDIC stages, and intensity is a multiply by a rounded reciprocal of 1530.
// The whole pipeline advances together whenever the output register is empty
// or is being drained, so a stall on the result side holds every stage and
// nothing is lost or repeated.
// -----------------------------------------------------------------------------
module rgb_to_hsi_converter_core #(
  parameter int unsigned ANGLE_BITS = rgbhsi_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ANGLE_BITS-1:0]      out_hue,
  output logic [12:0]                out_saturation,
  output logic [12:0]                out_intensity
);
  import rgbhsi_pkg::*;

  localparam int unsigned NS = ROT_STEPS;

  // One advance enable for all stages: the last register is free or leaving.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------------------
  // Stage 0: prepare CORDIC vector, saturation operands and intensity.
  // ---------------------------------------------------------------------------
  logic signed [9:0]    xv, dv;
  logic [9:0]           sum;
  logic [7:0]           mn;
  logic signed [CW-1:0] x0, y0, xs_nxt, ys_nxt;
  logic signed [ZW-1:0] zs_nxt;
  logic [SAT_NW-1:0]    num_nxt;
  logic [12:0]          inten_nxt;
  logic [31:0]          iprod;
  hue_ctl_t             ctl_nxt;

  always_comb begin
    xv  = 10'(signed'({2'b00, in_red}) * 2) - signed'({2'b00, in_green})
          - signed'({2'b00, in_blue});
    dv  = signed'({2'b00, in_green}) - signed'({2'b00, in_blue});
    sum = 10'(in_red) + 10'(in_green) + 10'(in_blue);
    mn  = (in_red < in_green) ? in_red : in_green;
    if (in_blue < mn) begin
      mn = in_blue;
    end
    x0 = CW'(xv) <<< 16;
    y0 = CW'(dv) * signed'(CW'(SQRT3_Q16));
    xs_nxt = x0;
    ys_nxt = y0;
    zs_nxt = '0;
    if (x0 < 0) begin
      if (y0 > 0) begin
        xs_nxt = y0;
        ys_nxt = -x0;
        zs_nxt = ZW'(1) <<< 30;
      end else begin
        xs_nxt = -y0;
        ys_nxt = x0;
        zs_nxt = -(ZW'(1) <<< 30);
      end
    end
    ctl_nxt.gray_gb = (dv == 0);
    ctl_nxt.xneg    = (xv < 0);
    ctl_nxt.dneg    = (dv < 0);
    // Rounded numerator 8192*(sum-3*min) + sum, divided later by 2*sum.
    num_nxt = SAT_NW'(({14'd0, sum - 10'(3 * mn)} << 13) + SAT_NW'(sum));
    // floor((8192*sum + 765)/1530) via multiply by ceil(2^36/1530).
    iprod     = 32'((64'((23'(sum) << 13) + 23'd765) * 64'd44914691) >> 36);
    inten_nxt = iprod[12:0];
  end

  logic                 v0_r;
  logic signed [CW-1:0] x0_r, y0_r;
  logic signed [ZW-1:0] z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Side pipeline: control, intensity and a one-bit-per-stage divider.
  // ---------------------------------------------------------------------------
  localparam int unsigned SD = NS + 2;
  hue_ctl_t          ctl_r   [SD];
  logic [12:0]       inten_r [SD];
  logic [SAT_DW-1:0] den_r   [SAT_QW+1];
  logic [SAT_NW-1:0] rem_r   [SAT_QW+1];
  logic [SAT_QW-1:0] quo_r   [SD];

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r       <= xs_nxt;
      y0_r       <= ys_nxt;
      z0_r       <= zs_nxt;
      ctl_r[0]   <= ctl_nxt;
      inten_r[0] <= inten_nxt;
      den_r[0]   <= {sum, 1'b0};
      rem_r[0]   <= num_nxt;
      quo_r[0]   <= '0;
    end
  end

  // Restoring division: stage k decides quotient bit SAT_QW-k; later stages
  // only carry the finished quotient.
  for (genvar k = 1; k < SD; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[k]   <= ctl_r[k-1];
        inten_r[k] <= inten_r[k-1];
      end
    end
    if (k <= SAT_QW) begin : g_div
      logic [SAT_NW+SAT_QW-1:0] trial;
      logic                     fits;
      logic [SAT_QW-1:0]        quo_nxt;
      always_comb begin
        trial   = (SAT_NW+SAT_QW)'(den_r[k-1]) << (SAT_QW-k);
        fits    = (den_r[k-1] != '0) &&
                  ((SAT_NW+SAT_QW)'(rem_r[k-1]) >= trial);
        quo_nxt = quo_r[k-1];
        if (fits) begin
          quo_nxt[SAT_QW-k] = 1'b1;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          den_r[k] <= den_r[k-1];
          rem_r[k] <= fits ? SAT_NW'((SAT_NW+SAT_QW)'(rem_r[k-1]) - trial)
                           : rem_r[k-1];
          quo_r[k] <= quo_nxt;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          quo_r[k] <= quo_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation stages.
  // ---------------------------------------------------------------------------
  logic                 cv [NS+1];
  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [ZW-1:0] cz [NS+1];

  assign cv[0] = v0_r;
  assign cx[0] = x0_r;
  assign cy[0] = y0_r;
  assign cz[0] = z0_r;

  for (genvar s = 0; s < NS; s++) begin : g_rot
    rgbhsi_cordic_stage #(.STEP(s)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (cv[s]),
      .x_in    (cx[s]),
      .y_in    (cy[s]),
      .z_in    (cz[s]),
      .vld_out (cv[s+1]),
      .x_out   (cx[s+1]),
      .y_out   (cy[s+1]),
      .z_out   (cz[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Hue wrap, clamp and round; side data is aligned at index NS.
  // ---------------------------------------------------------------------------
  logic signed [ZW-1:0] zf;
  logic [ZW-1:0]        zr;
  logic [ANGLE_BITS:0]  hr;
  logic [ANGLE_BITS-1:0] hue_nxt;
  hue_ctl_t             cl;

  always_comb begin
    cl = ctl_r[NS];
    zf = cz[NS];
    if (cl.dneg) begin
      zf = zf + (ZW'(1) <<< 32);
    end
    if (zf < 0) begin
      zf = '0;
    end
    zr = ZW'(zf) + (ZW'(1) << (31 - ANGLE_BITS));
    hr = (ANGLE_BITS+1)'(zr >> (32 - ANGLE_BITS));
    if (hr[ANGLE_BITS]) begin
      hue_nxt = '1;
    end else begin
      hue_nxt = hr[ANGLE_BITS-1:0];
    end
    if (cl.gray_gb) begin
      hue_nxt = cl.xneg ? (ANGLE_BITS)'(1 << (ANGLE_BITS - 1)) : '0;
    end
  end

  logic                  vh_r;
  logic [ANGLE_BITS-1:0] hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (adv) begin
      vh_r <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= hue_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue        <= hue_r;
      out_saturation <= quo_r[SD-1];
      out_intensity  <= inten_r[SD-1];
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= 13'd4096 && out_intensity <= 13'd4096)
    else $error("result out of range");
`endif

endmodule
`default_nettype wire

>>> src/rgbhsi_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to HSI CORDIC stage
// One registered vectoring rotation with a fixed shift, holding under stall.
// -----------------------------------------------------------------------------
module rgbhsi_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       vld_in,
  input  wire logic signed [rgbhsi_pkg::CW-1:0] x_in,
  input  wire logic signed [rgbhsi_pkg::CW-1:0] y_in,
  input  wire logic signed [rgbhsi_pkg::ZW-1:0] z_in,
  output logic                            vld_out,
  output logic signed [rgbhsi_pkg::CW-1:0] x_out,
  output logic signed [rgbhsi_pkg::CW-1:0] y_out,
  output logic signed [rgbhsi_pkg::ZW-1:0] z_out
);
  import rgbhsi_pkg::*;

  logic signed [CW-1:0] x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_nxt, tv;

  // Arithmetic right shift is the floor shift of the model.
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    tv = signed'(atan_turn(STEP));
    if (y_in > 0) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + tv;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - tv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out <= x_nxt;
      y_out <= y_nxt;
      z_out <= z_nxt;
    end
  end

endmodule
`default_nettype wire

>>> verif/rgb_to_hsi_scoreboard.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// RGB to HSI checker
// Watches both channels, predicts hue, saturation and intensity for every
// accepted pixel and compares each result transaction in order.
// -----------------------------------------------------------------------------
module rgb_to_hsi_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_hue,
  input  logic [12:0] out_saturation,
  input  logic [12:0] out_intensity,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [11:0] hue;
    logic [12:0] sat;
    logic [12:0] inten;
  } hsi_t;

  hsi_t hsi_q[$];

  longint arctan_tab[28] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005};

  // Arithmetic shift of a signed longint is a floor shift.
  function automatic logic [11:0] calc_hue(longint r, longint g, longint b);
    longint d, x, y, z, t, dx, dy, h;
    d = g - b;
    z = 0;
    if (d == 0) return (2 * r - g - b < 0) ? 12'd2048 : 12'd0;
    x = (2 * r - g - b) * 65536;
    y = d * 113512;
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = 64'sd1 << 30;
      end else begin
        x = -y; y = t; z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    if (d < 0) z += 64'sd1 << 32;
    if (z < 0) z = 0;
    h = (z + (64'sd1 << 19)) >>> 20;
    if (h > 4095) h = 4095;
    return h[11:0];
  endfunction

  function automatic hsi_t calc_hsi(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsi_t e;
    longint sum, mn;
    sum = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    e.sat = (sum == 0) ? 13'd0 : 13'((2 * 4096 * (sum - 3 * mn) + sum) / (2 * sum));
    e.inten = 13'((2 * 4096 * sum + 765) / 1530);
    e.hue = calc_hue(r, g, b);
    return e;
  endfunction

  always @(posedge clk) begin
    hsi_t e;
    if (!rst_n) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) hsi_q.push_back(calc_hsi(in_red, in_green, in_blue));
      if (out_valid && !out_stall) begin
        if (hsi_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = hsi_q.pop_front();
          if (e.hue !== out_hue || e.sat !== out_saturation || e.inten !== out_intensity) begin
            if (fail_count < 10)
              $display("mismatch: exp h=%0d s=%0d i=%0d got h=%0d s=%0d i=%0d",
                       e.hue, e.sat, e.inten, out_hue, out_saturation, out_intensity);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= hsi_q.size();
    end
  end

endmodule

>>> verif/tb_rgb_to_hsi_converter_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// RGB to HSI converter testbench
// Drives directed and random pixels under several idle and stall mixes and
// reports the verdict from the checker's failure count.
// -----------------------------------------------------------------------------
module tb_rgb_to_hsi_converter_core;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_hue;
  logic [12:0] out_saturation, out_intensity;
  int          fail_count, pending;
  // Percent chance that the sender idles and that the receiver stalls.
  int          idle_pct = 0, stall_pct = 0;
  logic [7:0]  pix_tab[24][3];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_to_hsi_converter_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall), .out_hue(out_hue),
    .out_saturation(out_saturation), .out_intensity(out_intensity));

  rgb_to_hsi_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall), .out_hue(out_hue),
    .out_saturation(out_saturation), .out_intensity(out_intensity),
    .fail_count(fail_count), .pending(pending));

  // The receiver stalls at random, changing its stall on the falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Sends one pixel transaction. Optional idle cycles come first, then the
  // payload is held until the core accepts it at a rising edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random pixel: uniform half the time, else a gray, green-equals-blue, near-gray
  // or extreme-red pixel to hit the special paths.
  task automatic send_random;
    logic [7:0] r, g, b;
    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
    case ($urandom_range(7))
      0: begin g = r; b = r; end
      1: b = g;
      2: begin r = $urandom_range(1) ? 8'hFF : 8'h00; end
      3: begin g = 8'(r + $urandom_range(2)); b = r; end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    // Directed pixels: black, white, primaries, secondaries, grays, the
    // green-equals-blue cases on both sides of red, and hues near a full turn.
    pix_tab = '{
      '{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}, '{1, 1, 1},
      '{255, 0, 0}, '{0, 255, 0}, '{0, 0, 255}, '{255, 255, 0},
      '{0, 255, 255}, '{255, 0, 255}, '{200, 50, 50}, '{10, 90, 90},
      '{255, 0, 1}, '{255, 1, 0}, '{255, 254, 255}, '{0, 1, 0},
      '{0, 0, 1}, '{1, 0, 0}, '{170, 85, 255}, '{85, 170, 255},
      '{255, 128, 129}, '{254, 255, 255}, '{255, 254, 254}, '{0, 255, 254}};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (pix_tab[i]) send_pixel(pix_tab[i][0], pix_tab[i][1], pix_tab[i][2]);
    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      repeat (460) send_random();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("tb_rgb_to_hsi_converter_core: done, clean");
    else $display("tb_rgb_to_hsi_converter_core: done, errors");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("tb_rgb_to_hsi_converter_core: done, errors");
    $finish;
  end

endmodule
